>>> rtl/core/hrlp_pkg.sv
package hrlp_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_METHOD  = 3'd1,
		ST_NO_LINE     = 3'd2,
		ST_NO_METHOD   = 3'd3,
		ST_NO_URL      = 3'd4,
		ST_NO_VERSION  = 3'd5,
		ST_BAD_VERSION = 3'd6
	} status_t;

	localparam logic [1:0] METH_GET  = 2'd0;
	localparam logic [1:0] METH_HEAD = 2'd1;
	localparam logic [1:0] METH_NONE = 2'd2;

	// candidate tokens: GET, HEAD, HTTP/1.0, HTTP/1.1
	localparam logic [1:0] CAND_GET    = 2'd0;
	localparam logic [1:0] CAND_HEAD   = 2'd1;
	localparam logic [1:0] CAND_HTTP10 = 2'd2;
	localparam logic [1:0] CAND_HTTP11 = 2'd3;

	// One queue entry: what one accepted byte produced
	typedef struct packed {
		logic       url_v;
		logic [7:0] url_byte;
		logic       st_v;
		status_t    status;
		logic [1:0] method;
		logic       version;
	} entry_t;

	function automatic logic [3:0] cand_len(input logic [1:0] k);
		logic [3:0] len;
		case (k)
			CAND_GET:  len = 4'd3;
			CAND_HEAD: len = 4'd4;
			default:   len = 4'd8;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] cand_char(input logic [1:0] k, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case (k)
			CAND_GET: begin
				case (pos)
					3'd0:    ch = "G";
					3'd1:    ch = "E";
					3'd2:    ch = "T";
					default: ch = 8'h00;
				endcase
			end
			CAND_HEAD: begin
				case (pos)
					3'd0:    ch = "H";
					3'd1:    ch = "E";
					3'd2:    ch = "A";
					3'd3:    ch = "D";
					default: ch = 8'h00;
				endcase
			end
			default: begin
				case (pos)
					3'd0:    ch = "H";
					3'd1:    ch = "T";
					3'd2:    ch = "T";
					3'd3:    ch = "P";
					3'd4:    ch = "/";
					3'd5:    ch = "1";
					3'd6:    ch = ".";
					default: ch = (k == CAND_HTTP11) ? "1" : "0";
				endcase
			end
		endcase
		return ch;
	endfunction

endpackage

>>> rtl/core/hrlp_in_if.sv
interface hrlp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

>>> rtl/core/hrlp_out_if.sv
interface hrlp_out_if;
	logic       valid;
	logic       ready;
	logic       is_status;
	logic [7:0] url_byte;
	logic [2:0] status;
	logic [1:0] method;
	logic       version;

	modport source (
		output valid, output is_status, output url_byte, output status,
		output method, output version, input ready
	);
	modport sink (
		input valid, input is_status, input url_byte, input status,
		input method, input version, output ready
	);
endinterface

>>> rtl/core/hrlp_front.sv
module hrlp_front
	import hrlp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	hrlp_in_if.sink    request,
	input  logic       full,
	output logic       push,
	output entry_t     entry
);

	typedef enum logic [2:0] {
		PH_SEEK_LINE   = 3'd0,
		PH_PRE_METHOD  = 3'd1,
		PH_METHOD      = 3'd2,
		PH_PRE_URL     = 3'd3,
		PH_URL         = 3'd4,
		PH_PRE_VERSION = 3'd5,
		PH_VERSION     = 3'd6
	} phase_t;

	typedef struct packed {
		status_t    code;
		logic       ver;
		logic [1:0] method;
	} close_t;

	phase_t     phase_q, phase_n;
	logic [3:0] match_pos_q, match_pos_n;
	logic [3:0] cand_q, cand_n;
	logic [1:0] method_q, method_n;
	logic       finished_q, finished_n;
	logic       url_v, st_v, done;
	status_t    code;
	logic       ver;
	close_t     cl;
	logic       accept;
	logic [7:0] c;

	function automatic logic hit(input logic [3:0] flags, input logic [3:0] pos,
			input logic [1:0] k);
		return flags[k] && (pos == cand_len(k));
	endfunction

	// Drop candidates that cannot match this byte at this position
	function automatic logic [3:0] match(input logic [3:0] flags, input logic [3:0] pos,
			input logic hi, input logic [7:0] ch);
		logic [3:0] f;
		logic [1:0] k;
		f = flags;
		for (int j = 0; j < 2; j++) begin
			k = {hi, j[0]};
			if (f[k] && (pos >= cand_len(k) || cand_char(k, pos[2:0]) != ch))
				f[k] = 1'b0;
		end
		return f;
	endfunction

	function automatic logic [3:0] inc_sat(input logic [3:0] pos);
		return (pos == 4'hF) ? pos : pos + 4'd1;
	endfunction

	function automatic logic [1:0] take_method(input logic [3:0] flags, input logic [3:0] pos);
		logic [1:0] m;
		if (hit(flags, pos, CAND_GET))
			m = METH_GET;
		else if (hit(flags, pos, CAND_HEAD))
			m = METH_HEAD;
		else
			m = METH_NONE;
		return m;
	endfunction

	// Status for a line end seen in the given phase
	function automatic close_t line_end(input phase_t ph, input logic [3:0] flags,
			input logic [3:0] pos, input logic [1:0] mf);
		close_t r;
		r.code = ST_NO_LINE;
		r.ver = 1'b0;
		r.method = mf;
		case (ph)
			PH_PRE_METHOD: r.code = ST_NO_METHOD;
			PH_METHOD: begin
				r.method = take_method(flags, pos);
				r.code = (r.method != METH_NONE) ? ST_NO_URL : ST_BAD_METHOD;
			end
			PH_PRE_URL:     r.code = ST_NO_URL;
			PH_URL:         r.code = ST_NO_VERSION;
			PH_PRE_VERSION: r.code = ST_NO_VERSION;
			PH_VERSION: begin
				if (hit(flags, pos, CAND_HTTP11)) begin
					r.code = ST_OK;
					r.ver = 1'b1;
				end else if (hit(flags, pos, CAND_HTTP10)) begin
					r.code = ST_OK;
				end else begin
					r.code = ST_BAD_VERSION;
				end
			end
			default: r.code = ST_NO_LINE;
		endcase
		return r;
	endfunction

	assign request.ready = !full;
	assign accept = request.valid && !full;
	assign c = request.data_byte;

	// Classify one byte: next state and the results it causes
	always_comb begin
		phase_n = phase_q;
		match_pos_n = match_pos_q;
		cand_n = cand_q;
		method_n = method_q;
		finished_n = finished_q;
		url_v = 1'b0;
		st_v = 1'b0;
		done = 1'b0;
		code = ST_OK;
		ver = 1'b0;
		cl = '0;
		if (!finished_q) begin
			if (c != 8'h00) begin
				if (phase_n == PH_SEEK_LINE) begin
					if (c == CH_LF)
						done = 1'b1;
					else
						phase_n = PH_PRE_METHOD;
				end
				if (!done && c == CH_LF && phase_n != PH_SEEK_LINE) begin
					cl = line_end(phase_n, cand_n, match_pos_n, method_n);
					method_n = cl.method;
					st_v = 1'b1;
					code = cl.code;
					ver = cl.ver;
					finished_n = 1'b1;
					done = 1'b1;
				end
				if (!done) begin
					case (phase_n)
						PH_PRE_METHOD: begin
							if (c != CH_SP) begin
								phase_n = PH_METHOD;
								cand_n = match(4'hF, 4'd0, 1'b0, c);
								match_pos_n = 4'd1;
							end
						end
						PH_METHOD: begin
							if (c == CH_SP) begin
								method_n = take_method(cand_n, match_pos_n);
								if (method_n != METH_NONE) begin
									phase_n = PH_PRE_URL;
								end else begin
									st_v = 1'b1;
									code = ST_BAD_METHOD;
									finished_n = 1'b1;
								end
							end else begin
								cand_n = match(cand_n, match_pos_n, 1'b0, c);
								match_pos_n = inc_sat(match_pos_n);
							end
						end
						PH_PRE_URL: begin
							// first URL byte is dropped
							if (c != CH_SP)
								phase_n = PH_URL;
						end
						PH_URL: begin
							if (c == CH_SP)
								phase_n = PH_PRE_VERSION;
							else
								url_v = 1'b1;
						end
						PH_PRE_VERSION: begin
							if (c != CH_CR) begin
								phase_n = PH_VERSION;
								cand_n = match(4'hF, 4'd0, 1'b1, c);
								match_pos_n = 4'd1;
							end
						end
						PH_VERSION: begin
							if (c == CH_CR) begin
								cl = line_end(phase_n, cand_n, match_pos_n, method_n);
								method_n = cl.method;
								st_v = 1'b1;
								code = cl.code;
								ver = cl.ver;
								finished_n = 1'b1;
							end else begin
								cand_n = match(cand_n, match_pos_n, 1'b1, c);
								match_pos_n = inc_sat(match_pos_n);
							end
						end
						default: ;
					endcase
				end
			end
			// end of string or the buffer's last byte closes the line
			if (!finished_n && (c == 8'h00 || request.end_of_buffer)) begin
				cl = line_end(phase_n, cand_n, match_pos_n, method_n);
				method_n = cl.method;
				st_v = 1'b1;
				code = cl.code;
				ver = cl.ver;
				finished_n = 1'b1;
			end
		end
	end

	// Build the queue entry
	always_comb begin
		entry.url_v = url_v;
		entry.url_byte = c;
		entry.st_v = st_v;
		entry.status = code;
		entry.method = method_n;
		entry.version = (code == ST_OK) ? ver : 1'b0;
	end

	assign push = accept && (url_v || st_v);

	// Hold parse state; return to start after the buffer's last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK_LINE;
			match_pos_q <= 4'd0;
			cand_q <= 4'hF;
			method_q <= METH_NONE;
			finished_q <= 1'b0;
		end else if (accept) begin
			if (request.end_of_buffer) begin
				phase_q <= PH_SEEK_LINE;
				match_pos_q <= 4'd0;
				cand_q <= 4'hF;
				method_q <= METH_NONE;
				finished_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				match_pos_q <= match_pos_n;
				cand_q <= cand_n;
				method_q <= method_n;
				finished_q <= finished_n;
			end
		end
	end

endmodule

>>> rtl/core/hrlp_queue.sv
module hrlp_queue
	import hrlp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t entry,
	input  logic   pop,
	output logic   full,
	output logic   empty,
	output entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= entry;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/core/hrlp_back.sv
module hrlp_back
	import hrlp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  entry_t     head,
	output logic       pop,
	hrlp_out_if.source result
);

	logic url_sent_q;
	logic show_url;
	logic last_part;
	logic taken;

	// Pick the part of the head entry to present
	assign show_url = head.url_v && !url_sent_q;
	assign last_part = !show_url || !head.st_v;
	assign taken = result.valid && result.ready;

	assign result.valid = !empty;
	assign result.is_status = !show_url;
	assign result.url_byte = show_url ? head.url_byte : 8'h00;
	assign result.status = show_url ? ST_OK : head.status;
	assign result.method = show_url ? METH_GET : head.method;
	assign result.version = show_url ? 1'b0 : head.version;

	assign pop = taken && last_part;

	// Track whether the URL byte of the head entry has left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_sent_q <= 1'b0;
		end else if (taken) begin
			url_sent_q <= !last_part;
		end
	end

endmodule

>>> rtl/core/http_request_line_parser.sv
// HTTP/1.x request-line parser. The request stream takes one buffer byte per
// cycle; a byte is classified in the cycle it is accepted by the parse state
// machine, and the results it causes (a URL byte, the closing status, or both
// on the buffer's final byte) go into a queue of QDEPTH entries. The
// result stream delivers one item per cycle from the queue head, so a byte that
// causes a URL byte and the status yields two items, URL first. Input stalls
// only when the queue is full; the result side stalls independently. The
// first URL character is dropped, only GET and HEAD methods and HTTP/1.0 or
// HTTP/1.1 versions are accepted, and bytes after the status are ignored until
// the byte flagged end_of_buffer, which returns the parser to its start state.
module http_request_line_parser
	import hrlp_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	hrlp_in_if.sink    request,
	hrlp_out_if.source result
);

	entry_t push_entry;
	entry_t head;
	logic   push, pop, full, empty;

	hrlp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.full    (full),
		.push    (push),
		.entry   (push_entry)
	);

	hrlp_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.entry  (push_entry),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	hrlp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

>>> sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hrlp_pkg::*;

	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 20;

	// parse position within the request line
	typedef enum logic [2:0] {
		LINE_SEEK,
		METHOD_SKIP,
		METHOD_READ,
		URL_SKIP,
		URL_READ,
		VERSION_SKIP,
		VERSION_READ
	} line_phase_t;

	typedef struct packed {
		logic       is_status;
		logic [7:0] url_byte;
		status_t    status;
		logic [1:0] method;
		logic       version;
	} line_result_t;

	logic clk;
	logic arst_n;

	hrlp_in_if  req_if ();
	hrlp_out_if res_if ();

	http_request_line_parser uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_if),
		.result  (res_if)
	);

	// parser state as the checker sees it
	line_phase_t  phase_q;
	logic [3:0]   tok_pos;
	logic [3:0]   tok_alive;
	logic [1:0]   seen_method;
	logic         line_done;

	line_result_t expected_q[$];
	logic [7:0]   req_buf[$];

	int fail_count = 0;
	int bytes_sent = 0;
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_results = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL http_request_line_parser");
		$finish;
	end

	//------------------------------------------------------------------
	// Request line predictor
	//------------------------------------------------------------------

	function automatic logic [3:0] token_len(input logic [1:0] k);
		case (k)
			CAND_GET:  return 4'd3;
			CAND_HEAD: return 4'd4;
			default:   return 4'd8;
		endcase
	endfunction

	function automatic logic [7:0] token_char(input logic [1:0] k, input logic [2:0] p);
		logic [63:0] txt;
		case (k)
			CAND_GET:    txt = {"GET", 40'h0};
			CAND_HEAD:   txt = {"HEAD", 32'h0};
			CAND_HTTP10: txt = "HTTP/1.0";
			default:     txt = "HTTP/1.1";
		endcase
		return txt[63 - 8 * p -: 8];
	endfunction

	function automatic void reset_line_state();
		phase_q     = LINE_SEEK;
		tok_pos     = 4'd0;
		tok_alive   = 4'hF;
		seen_method = METH_NONE;
		line_done   = 1'b0;
	endfunction

	function automatic void start_token();
		tok_pos   = 4'd0;
		tok_alive = 4'hF;
	endfunction

	// drop candidates of the pair at base that no longer match, then step
	function automatic void advance_token(input logic [1:0] base, input logic [7:0] c);
		for (int k = int'(base); k <= int'(base) + 1; k++) begin
			if (tok_alive[k] && (tok_pos >= token_len(2'(k)) ||
					token_char(2'(k), tok_pos[2:0]) != c))
				tok_alive[k] = 1'b0;
		end
		if (tok_pos != 4'd15)
			tok_pos++;
	endfunction

	function automatic logic token_hit(input logic [1:0] k);
		return tok_alive[k] && tok_pos == token_len(k);
	endfunction

	function automatic logic decide_method();
		if (token_hit(CAND_GET))
			seen_method = METH_GET;
		else if (token_hit(CAND_HEAD))
			seen_method = METH_HEAD;
		else
			seen_method = METH_NONE;
		return seen_method != METH_NONE;
	endfunction

	function automatic void push_url(input logic [7:0] c);
		line_result_t r;
		r = '0;
		r.url_byte = c;
		expected_q.push_back(r);
	endfunction

	function automatic void close_line(input status_t code, input logic ver);
		line_result_t r;
		r = '0;
		r.is_status = 1'b1;
		r.status    = code;
		r.method    = seen_method;
		r.version   = (code == ST_OK) ? ver : 1'b0;
		expected_q.push_back(r);
		line_done = 1'b1;
	endfunction

	// line ended by newline, carriage return in the version, string end or buffer end
	function automatic void end_line();
		case (phase_q)
			METHOD_SKIP: close_line(ST_NO_METHOD, 1'b0);
			METHOD_READ: begin
				if (decide_method())
					close_line(ST_NO_URL, 1'b0);
				else
					close_line(ST_BAD_METHOD, 1'b0);
			end
			URL_SKIP: close_line(ST_NO_URL, 1'b0);
			URL_READ, VERSION_SKIP: close_line(ST_NO_VERSION, 1'b0);
			VERSION_READ: begin
				if (token_hit(CAND_HTTP11))
					close_line(ST_OK, 1'b1);
				else if (token_hit(CAND_HTTP10))
					close_line(ST_OK, 1'b0);
				else
					close_line(ST_BAD_VERSION, 1'b0);
			end
			default: close_line(ST_NO_LINE, 1'b0);
		endcase
	endfunction

	function automatic void feed_byte(input logic [7:0] c);
		// leave the newline skip on the first other byte
		if (phase_q == LINE_SEEK && c != CH_LF)
			phase_q = METHOD_SKIP;
		if (phase_q == LINE_SEEK) begin
		end else if (c == CH_LF) begin
			end_line();
		end else begin
			case (phase_q)
				METHOD_SKIP: begin
					if (c != CH_SP) begin
						phase_q = METHOD_READ;
						start_token();
						advance_token(CAND_GET, c);
					end
				end
				METHOD_READ: begin
					if (c == CH_SP) begin
						if (decide_method())
							phase_q = URL_SKIP;
						else
							close_line(ST_BAD_METHOD, 1'b0);
					end else begin
						advance_token(CAND_GET, c);
					end
				end
				// first URL character is consumed without a result
				URL_SKIP: begin
					if (c != CH_SP)
						phase_q = URL_READ;
				end
				URL_READ: begin
					if (c == CH_SP)
						phase_q = VERSION_SKIP;
					else
						push_url(c);
				end
				VERSION_SKIP: begin
					if (c != CH_CR) begin
						phase_q = VERSION_READ;
						start_token();
						advance_token(CAND_HTTP10, c);
					end
				end
				VERSION_READ: begin
					if (c == CH_CR)
						end_line();
					else
						advance_token(CAND_HTTP10, c);
				end
				default: begin
				end
			endcase
		end
	endfunction

	function automatic void predict_item(input logic [7:0] c, input logic last);
		if (!line_done) begin
			if (c != 8'h00)
				feed_byte(c);
			if (!line_done && (c == 8'h00 || last))
				end_line();
		end
		if (last)
			reset_line_state();
	endfunction

	//------------------------------------------------------------------
	// Result side: ready generation and checking
	//------------------------------------------------------------------

	initial begin : result_ready_gen
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_results) begin
				// hold off long enough to fill the block and stall its input
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
				res_if.ready <= 1'b1;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		line_result_t exp_r;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: is_status %0h url_byte %0h status %0h",
					res_if.is_status, res_if.url_byte, res_if.status);
				fail_count++;
			end else begin
				exp_r = expected_q.pop_front();
				check_field("is_status", 8'(exp_r.is_status), 8'(res_if.is_status));
				check_field("url_byte", exp_r.url_byte, res_if.url_byte);
				check_field("status", 8'(exp_r.status), 8'(res_if.status));
				check_field("method", 8'(exp_r.method), 8'(res_if.method));
				check_field("version", 8'(exp_r.version), 8'(res_if.version));
			end
		end
	end

	//------------------------------------------------------------------
	// Request side
	//------------------------------------------------------------------

	// offer one byte, idling first now and then, and wait for the handshake
	task automatic send_item(input logic [7:0] c, input logic last);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.data_byte     <= c;
		req_if.end_of_buffer <= last;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		predict_item(c, last);
		bytes_sent++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			req_buf.push_back(s[i]);
	endtask

	task automatic add_byte(input logic [7:0] c);
		req_buf.push_back(c);
	endtask

	// send the collected buffer, flagging its final byte
	task automatic send_buffer();
		for (int i = 0; i < req_buf.size(); i++)
			send_item(req_buf[i], i == req_buf.size() - 1);
		req_buf.delete();
	endtask

	function automatic logic [7:0] token_byte();
		logic [7:0] c;
		if ($urandom_range(0, 4) != 0) begin
			c = 8'($urandom_range(8'h21, 8'h7E));
		end else begin
			c = 8'($urandom_range(1, 255));
			if (c == CH_SP || c == CH_LF)
				c = 8'hFF;
		end
		return c;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 7))
			0:       return CH_SP;
			1:       return CH_LF;
			2:       return CH_CR;
			3:       return 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_method();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: add_text("GET");
			4, 5, 6:    add_text("HEAD");
			7: begin
				case ($urandom_range(0, 4))
					0:       add_text("GE");
					1:       add_text("GETS");
					2:       add_text("HEA");
					3:       add_text("HEADER");
					default: add_text("get");
				endcase
			end
			default: repeat ($urandom_range(1, 6)) req_buf.push_back(token_byte());
		endcase
	endtask

	task automatic add_version();
		int start;
		start = req_buf.size();
		if ($urandom_range(0, 1))
			add_text("HTTP/1.1");
		else
			add_text("HTTP/1.0");
		case ($urandom_range(0, 9))
			// corrupt one character
			7: req_buf[start + $urandom_range(0, 7)] = token_byte();
			// cut short or run long
			8: begin
				if ($urandom_range(0, 1))
					repeat ($urandom_range(1, 7)) void'(req_buf.pop_back());
				else
					repeat ($urandom_range(1, 3)) req_buf.push_back(token_byte());
			end
			// replace with a random token, sometimes past the position limit
			9: begin
				while (req_buf.size() > start)
					void'(req_buf.pop_back());
				repeat ($urandom_range(1, 18)) req_buf.push_back(token_byte());
			end
			default: begin
			end
		endcase
	endtask

	task automatic add_terminator();
		case ($urandom_range(0, 5))
			0: begin
				add_byte(CH_CR);
				add_byte(CH_LF);
			end
			1: add_byte(CH_LF);
			2: add_byte(CH_CR);
			3: add_byte(8'h00);
			4: begin
			end
			default: begin
				add_byte(CH_CR);
				add_byte(CH_LF);
				repeat ($urandom_range(1, 8)) req_buf.push_back(noise_byte());
			end
		endcase
	endtask

	// mostly well-formed request lines with random content, some broken, some noise
	task automatic random_request();
		int shape;
		int keep;
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			repeat ($urandom_range(1, 24)) req_buf.push_back(noise_byte());
		end else begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) add_byte(CH_LF);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) add_byte(CH_SP);
			add_method();
			repeat ($urandom_range(1, 3)) add_byte(CH_SP);
			repeat ($urandom_range(1, 12)) req_buf.push_back(token_byte());
			add_byte(CH_SP);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) add_byte(CH_CR);
			add_version();
			add_terminator();
			// break the line: cut it off or plant an early string end
			if (shape == 1) begin
				keep = $urandom_range(1, req_buf.size());
				while (req_buf.size() > keep)
					void'(req_buf.pop_back());
			end else if (shape == 2) begin
				req_buf[$urandom_range(0, req_buf.size() - 1)] = 8'h00;
			end
		end
		send_buffer();
	endtask

	//------------------------------------------------------------------
	// Tests
	//------------------------------------------------------------------

	task automatic test_accepted_requests();
		add_text("GET /a HTTP/1.1");
		add_byte(CH_CR);
		add_byte(CH_LF);
		send_buffer();
		// version ends at the buffer end
		add_text("HEAD /x HTTP/1.0");
		send_buffer();
		// leading newlines, extra spaces, carriage returns before the version
		add_byte(CH_LF);
		add_byte(CH_LF);
		add_text("  GET  /ab ");
		add_byte(CH_CR);
		add_byte(CH_CR);
		add_text("HTTP/1.1");
		add_byte(CH_LF);
		send_buffer();
		// carriage return and high bytes inside the URL
		add_text("HEAD /a");
		add_byte(CH_CR);
		add_byte(8'hFF);
		add_byte(8'h80);
		add_text("b HTTP/1.0");
		add_byte(8'h00);
		send_buffer();
		// one-character URL gives no URL bytes
		add_text("GET / HTTP/1.1");
		add_byte(CH_CR);
		send_buffer();
	endtask

	task automatic test_missing_tokens();
		add_byte(CH_LF);
		send_buffer();
		add_byte(8'h00);
		send_buffer();
		add_text("   ");
		add_byte(CH_LF);
		send_buffer();
		add_text("GET");
		send_buffer();
		add_text("HEAD");
		add_byte(CH_LF);
		send_buffer();
		add_text("GET  ");
		add_byte(CH_LF);
		send_buffer();
		// final byte yields a URL byte and the status together
		add_text("GET /abc");
		send_buffer();
		add_text("HEAD /a ");
		add_byte(CH_LF);
		send_buffer();
	endtask

	task automatic test_bad_tokens();
		add_text("POST / HTTP/1.1");
		send_buffer();
		add_text("GE");
		send_buffer();
		add_byte(8'hFF);
		add_text(" /a HTTP/1.1");
		send_buffer();
		add_text("GET /a HTTP/1.2");
		add_byte(CH_CR);
		send_buffer();
		// overlong version saturates the match position
		add_text("GET /a HTTP/1.10000000000000000");
		add_byte(CH_CR);
		send_buffer();
		add_text("HEAD /a HTTP/1.");
		send_buffer();
	endtask

	task automatic test_string_end();
		add_text("GET /ab");
		add_byte(8'h00);
		add_text("junk");
		send_buffer();
		add_text("GET /a HTTP/1.0");
		add_byte(8'h00);
		add_byte(CH_LF);
		add_byte(8'hFF);
		send_buffer();
		add_text("GET /a HTTP/1.1");
		add_byte(CH_LF);
		send_buffer();
	endtask

	// keep offering URL bytes while the result side holds off
	task automatic test_result_backpressure();
		tx_gaps = 1'b0;
		hold_results = 1'b1;
		add_text("GET /");
		repeat (40) req_buf.push_back(token_byte());
		add_text(" HTTP/1.1");
		add_byte(CH_CR);
		add_byte(CH_LF);
		send_buffer();
		tx_gaps = 1'b1;
	endtask

	task automatic test_random_requests(input int n_bytes, input bit gaps);
		int start;
		start = bytes_sent;
		tx_gaps = gaps;
		rx_gaps = gaps;
		while (bytes_sent - start < n_bytes)
			random_request();
	endtask

	initial begin : main_seq
		req_if.valid         <= 1'b0;
		req_if.data_byte     <= 8'h00;
		req_if.end_of_buffer <= 1'b0;
		arst_n               <= 1'b0;
		reset_line_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_accepted_requests();
		test_missing_tokens();
		test_bad_tokens();
		test_string_end();
		test_result_backpressure();
		test_random_requests(320, 1'b1);
		test_random_requests(100, 1'b0);

		// drain the remaining results, then watch for strays
		req_if.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS http_request_line_parser");
		else
			$display("FAIL http_request_line_parser");
		$finish;
	end

endmodule
